// ===== hw/rtl/ptf_pkg.sv =====
// Shared constants, types and helpers for the page table replacement unit.
`timescale 1ns / 1ps

package ptf_pkg;

    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 64;
    localparam int PAGE_IN_W       = 8;
    localparam int FRAME_OUT_W     = 6;

    typedef struct packed {
        logic look;
        logic update;
        logic shift_all;
        logic shift_hit;
    } t_cell_ctrl;

    // Page number modulo the page count by restoring subtraction.
    function automatic logic [PAGE_IN_W-1:0] page_mod(input logic [PAGE_IN_W-1:0] value,
                                                      input int unsigned modulus);
        logic [31:0] rem;
        rem = {{(32-PAGE_IN_W){1'b0}}, value};
        for (int k = PAGE_IN_W - 1; k >= 0; k--) begin
            if (rem >= (32'(modulus) << k)) begin
                rem = rem - (32'(modulus) << k);
            end
        end
        return rem[PAGE_IN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ptf_cell.sv =====
// One slot of the order queue: resident page, its frame and lookup match.
`timescale 1ns / 1ps

module ptf_cell import ptf_pkg::*; #(
    parameter int PW  = 8,
    parameter int FW  = 6,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctrl    i_ctrl,
    input  logic [PW-1:0] i_look_page,
    input  logic [CW-1:0] i_write_pos,
    input  logic [PW-1:0] i_new_page,
    input  logic [FW-1:0] i_new_frame,
    input  logic          i_nb_valid,
    input  logic [PW-1:0] i_nb_page,
    input  logic [FW-1:0] i_nb_frame,
    input  logic          i_hit_upto,
    input  logic [FW-1:0] i_frame_or,
    output logic          o_valid,
    output logic [PW-1:0] o_page,
    output logic [FW-1:0] o_frame,
    output logic          o_hit,
    output logic          o_hit_upto,
    output logic [FW-1:0] o_frame_or
);

    logic          r_valid, n_valid;
    logic [PW-1:0] r_page, n_page;
    logic [FW-1:0] r_frame, n_frame;
    logic          r_hit;
    logic          w_shift;

    assign o_valid    = r_valid;
    assign o_page     = r_page;
    assign o_frame    = r_frame;
    assign o_hit      = r_hit;
    assign o_hit_upto = i_hit_upto | r_hit;
    assign o_frame_or = i_frame_or | (r_hit ? r_frame : '0);

    // a removed entry below or at this slot moves everything above down by one
    assign w_shift = i_ctrl.shift_all | (i_ctrl.shift_hit & o_hit_upto);

    always_comb begin
        n_valid = r_valid;
        n_page  = r_page;
        n_frame = r_frame;
        if (i_ctrl.update) begin
            if (i_write_pos == CW'(IDX)) begin
                n_valid = 1'b1;
                n_page  = i_new_page;
                n_frame = i_new_frame;
            end else if (w_shift) begin
                n_valid = i_nb_valid;
                n_page  = i_nb_page;
                n_frame = i_nb_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= i_ctrl.look & r_valid & (r_page == i_look_page);
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_frame <= n_frame;
    end

endmodule

// ===== hw/rtl/page_table_fifo_lru_replacement_unit.sv =====
// Top level: page translation with FIFO or LRU replacement over a chain of queue cells.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  request   | start in, busy out         | i_page_number
//  result    | o_done strobe, one cycle   | o_frame_number, o_page_fault, o_evicted,
//            |                            | o_victim_page
//  config    | i_cfg_we                   | i_cfg_data (policy: 0 FIFO, 1 LRU)
//
// In order: the accept edge registers the page, in S_LOOK every cell compares its page,
// and in S_UPD the match and frame ripple down the chain and the queue updates.
// busy is high in S_LOOK and S_UPD after a transfer; the result strobe comes with busy low.
// Synchronous reset clears the cell valid bits and the count at once; no clearing pass.
// The receiver cannot stall: o_done is high for a single cycle; the result registers hold until the next update.
`timescale 1ns / 1ps

module page_table_fifo_lru_replacement_unit import ptf_pkg::*; #(
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_IN_W-1:0]   i_page_number,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    output logic                   o_done,
    output logic [FRAME_OUT_W-1:0] o_frame_number,
    output logic                   o_page_fault,
    output logic                   o_evicted,
    output logic [PAGE_IN_W-1:0]   o_victim_page
);

    localparam int PW = (PAGE_COUNT > (1 << PAGE_IN_W)) ? PAGE_IN_W : $clog2(PAGE_COUNT);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int CW = $clog2(FRAME_COUNT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic                   r_policy_lru;
    logic [PW-1:0]          r_page;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_done;
    logic [FRAME_OUT_W-1:0] r_frame_out;
    logic                   r_fault_out;
    logic                   r_evict_out;
    logic [PAGE_IN_W-1:0]   r_victim_out;

    logic [PAGE_IN_W-1:0]   w_page_mod;
    t_cell_ctrl             w_ctrl;
    logic [CW-1:0]          w_write_pos;
    logic [FW-1:0]          w_new_frame;
    logic                   w_any_hit;
    logic                   w_full;
    logic                   w_evict;
    logic [FW+FRAME_OUT_W-1:0] w_frame_ext;
    logic [PW+PAGE_IN_W-1:0]   w_victim_ext;

    logic [FRAME_COUNT:0]   w_valid;
    logic [PW-1:0]          w_page  [FRAME_COUNT+1];
    logic [FW-1:0]          w_frame [FRAME_COUNT+1];
    logic [FRAME_COUNT:0]   w_hit_upto;
    logic [FW-1:0]          w_frame_or [FRAME_COUNT+1];
    logic [FRAME_COUNT-1:0] w_hits;

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_frame_number = r_frame_out;
    assign o_page_fault   = r_fault_out;
    assign o_evicted      = r_evict_out;
    assign o_victim_page  = r_victim_out;

    assign w_page_mod = page_mod(i_page_number, PAGE_COUNT);

    // chain ends
    assign w_valid[FRAME_COUNT]    = 1'b0;
    assign w_page[FRAME_COUNT]     = '0;
    assign w_frame[FRAME_COUNT]    = '0;
    assign w_hit_upto[0]           = 1'b0;
    assign w_frame_or[0]           = '0;

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        ptf_cell #(
            .PW  (PW),
            .FW  (FW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_look_page (r_page),
            .i_write_pos (w_write_pos),
            .i_new_page  (r_page),
            .i_new_frame (w_new_frame),
            .i_nb_valid  (w_valid[g+1]),
            .i_nb_page   (w_page[g+1]),
            .i_nb_frame  (w_frame[g+1]),
            .i_hit_upto  (w_hit_upto[g]),
            .i_frame_or  (w_frame_or[g]),
            .o_valid     (w_valid[g]),
            .o_page      (w_page[g]),
            .o_frame     (w_frame[g]),
            .o_hit       (w_hits[g]),
            .o_hit_upto  (w_hit_upto[g+1]),
            .o_frame_or  (w_frame_or[g+1])
        );
    end

    assign w_any_hit = w_hit_upto[FRAME_COUNT];
    assign w_full    = (r_count == CW'(FRAME_COUNT));
    assign w_evict   = !w_any_hit && w_full;

    always_comb begin
        w_ctrl.look      = (r_state == S_LOOK);
        w_ctrl.update    = (r_state == S_UPD) && (!w_any_hit || r_policy_lru);
        w_ctrl.shift_all = w_evict;
        w_ctrl.shift_hit = w_any_hit && r_policy_lru;
        if (w_ctrl.shift_all || w_ctrl.shift_hit) begin
            w_write_pos = r_count - CW'(1);
        end else begin
            w_write_pos = r_count;
        end
        priority if (w_any_hit) begin
            w_new_frame = w_frame_or[FRAME_COUNT];
        end else if (w_full) begin
            w_new_frame = w_frame[0];
        end else begin
            w_new_frame = r_count[FW-1:0];
        end
    end

    assign w_frame_ext  = {{FRAME_OUT_W{1'b0}}, w_new_frame};
    assign w_victim_ext = {{PAGE_IN_W{1'b0}}, w_page[0]};

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
                if (!w_any_hit && !w_full) begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_policy_lru <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_UPD);
            if (i_cfg_we) begin
                r_policy_lru <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_page <= w_page_mod[PW-1:0];
        end
        if (r_state == S_UPD) begin
            r_frame_out  <= w_frame_ext[FRAME_OUT_W-1:0];
            r_fault_out  <= !w_any_hit;
            r_evict_out  <= w_evict;
            r_victim_out <= w_evict ? w_victim_ext[PAGE_IN_W-1:0] : '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_hits))
        else $error("more than one cell matched the page");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("queue count disagrees with valid cells");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (o_done && !busy))
        else $error("result strobe missing after update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !w_any_hit && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("fault with a free frame did not grow the queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> o_page_fault)
        else $error("eviction without a fault");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the page table unit with FIFO and LRU replacement.
`timescale 1ns / 1ps

module tb_top import ptf_pkg::*;;

    localparam int  PAGES         = 256;
    localparam int  FRAMES        = 64;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  MAX_REPORTS   = 10;
    localparam bit  POLICY_FIFO   = 1'b0;
    localparam bit  POLICY_LRU    = 1'b1;

    typedef enum bit {JOB_ACCESS, JOB_POLICY} t_job_kind;

    typedef struct {
        t_job_kind      kind;
        logic [7:0]     page;
        bit             policy;
        int unsigned    gap;
    } t_job;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic                   fault;
        logic                   evicted;
        logic [PAGE_IN_W-1:0]   victim;
    } t_xlat;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PAGE_IN_W-1:0]   i_page_number = '0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_data = 1'b0;
    logic                   o_done;
    logic [FRAME_OUT_W-1:0] o_frame_number;
    logic                   o_page_fault;
    logic                   o_evicted;
    logic [PAGE_IN_W-1:0]   o_victim_page;

    page_table_fifo_lru_replacement_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_page_number  (i_page_number),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_frame_number (o_frame_number),
        .o_page_fault   (o_page_fault),
        .o_evicted      (o_evicted),
        .o_victim_page  (o_victim_page)
    );

    // Predictor state
    bit                     lru_mode = POLICY_FIFO;
    bit                     resident [PAGES];
    logic [FRAME_OUT_W-1:0] frame_of [PAGES];
    bit                     frame_free [FRAMES];
    logic [7:0]             age_q [$];

    t_job   job_q [$];
    t_xlat  xlat_expected_q [$];

    int unsigned cycle_cnt = 0;
    int unsigned quiet_cnt = 0;
    int unsigned n_access = 0;
    int unsigned n_results = 0;
    int unsigned n_faults = 0;
    int unsigned n_evicts = 0;
    int unsigned n_policy = 0;
    int unsigned n_errors = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_xlat translate_page(input logic [7:0] page);
        t_xlat      r;
        int         slot;
        logic [7:0] vp;
        r = '0;
        slot = -1;
        if (resident[page]) begin
            r.frame = frame_of[page];
            if (lru_mode == POLICY_LRU) begin
                for (int k = 0; k < age_q.size(); k++) begin
                    if (age_q[k] == page) begin
                        age_q.delete(k);
                        break;
                    end
                end
                age_q.insert(age_q.size(), page);
            end
        end else begin
            r.fault = 1'b1;
            for (int k = 0; k < FRAMES; k++) begin
                if (frame_free[k]) begin
                    slot = k;
                    break;
                end
            end
            if (slot >= 0) begin
                frame_free[slot] = 1'b0;
                r.frame = slot[FRAME_OUT_W-1:0];
            end else if (age_q.size() != 0) begin
                vp = age_q[0];
                age_q.delete(0);
                r.frame = frame_of[vp];
                resident[vp] = 1'b0;
                r.evicted = 1'b1;
                r.victim = vp;
            end
            resident[page] = 1'b1;
            frame_of[page] = r.frame;
            if (age_q.size() < FRAMES) age_q.insert(age_q.size(), page);
        end
        return r;
    endfunction

    // Driver: one access or one policy write per job
    always @(posedge i_clk) begin
        logic start_nx;
        logic we_nx;
        t_job job;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            quiet_cnt = 0;
        end else begin
            start_nx = start;
            we_nx = 1'b0;
            if (start && !busy) begin
                xlat_expected_q.insert(xlat_expected_q.size(), translate_page(i_page_number));
                n_access++;
                start_nx = 1'b0;
            end
            if (xlat_expected_q.size() != 0 || start_nx || busy) quiet_cnt = 0;
            else if (quiet_cnt < SETTLE_CYCLES) quiet_cnt++;
            if (!start_nx && job_q.size() != 0) begin
                if (job_q[0].gap != 0) begin
                    job_q[0].gap = job_q[0].gap - 1;
                end else if (job_q[0].kind == JOB_ACCESS) begin
                    job = job_q[0];
                    job_q.delete(0);
                    i_page_number <= job.page;
                    start_nx = 1'b1;
                end else if (quiet_cnt >= SETTLE_CYCLES) begin
                    job = job_q[0];
                    job_q.delete(0);
                    i_cfg_data <= job.policy;
                    we_nx = 1'b1;
                    lru_mode = job.policy;
                    n_policy++;
                    quiet_cnt = 0;
                end
            end
            start <= start_nx;
            i_cfg_we <= we_nx;
        end
    end

    // Monitor: every strobe is a transfer
    always @(posedge i_clk) begin
        t_xlat got;
        t_xlat want;
        if (i_rst_n && o_done) begin
            got = {o_frame_number, o_page_fault, o_evicted, o_victim_page};
            n_results++;
            if (xlat_expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: frame %0d fault %0b evicted %0b victim %0d",
                             got.frame, got.fault, got.evicted, got.victim);
            end else begin
                want = xlat_expected_q[0];
                xlat_expected_q.delete(0);
                if (got.fault) n_faults++;
                if (got.evicted) n_evicts++;
                if (got.frame !== want.frame || got.fault !== want.fault ||
                    got.evicted !== want.evicted || got.victim !== want.victim) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"mismatch at result %0d: exp frame %0d fault %0b ",
                                  "evicted %0b victim %0d, got frame %0d fault %0b ",
                                  "evicted %0b victim %0d"},
                                 n_results, want.frame, want.fault, want.evicted,
                                 want.victim, got.frame, got.fault, got.evicted,
                                 got.victim);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, xlat_expected_q.size());
            $display("[page_table_fifo_lru_replacement_unit] ERROR");
            $finish;
        end
    end

    int unsigned burst_left = 0;

    function automatic int unsigned draw_gap();
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 14);
    endfunction

    task automatic queue_access(input logic [7:0] page);
        t_job j;
        j.kind = JOB_ACCESS;
        j.page = page;
        j.policy = POLICY_FIFO;
        j.gap = draw_gap();
        job_q.insert(job_q.size(), j);
    endtask

    task automatic queue_policy(input bit policy);
        t_job j;
        j.kind = JOB_POLICY;
        j.page = '0;
        j.policy = policy;
        j.gap = 0;
        job_q.insert(job_q.size(), j);
    endtask

    // Working-set traffic: a hot set that fits in memory, a wider set of up to 120 pages that can force
    // evictions, and some scattered pages
    task automatic queue_phase(input int unsigned count);
        logic [7:0]  base;
        int unsigned wsize;
        int unsigned r;
        base = '0;
        wsize = 16;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                base = 8'($urandom_range(0, 255));
                wsize = $urandom_range(16, 120);
            end
            r = $urandom_range(0, 99);
            if (r < 10) queue_access(8'($urandom_range(0, 255)));
            else if (r < 60) queue_access(8'(base + $urandom_range(0, 31)));
            else queue_access(8'(base + $urandom_range(0, wsize - 1)));
        end
    endtask

    initial begin
        for (int k = 0; k < PAGES; k++) begin
            resident[k] = 1'b0;
            frame_of[k] = '0;
        end
        for (int k = 0; k < FRAMES; k++) frame_free[k] = 1'b1;

        queue_policy(POLICY_FIFO);
        queue_access(8'h00);
        queue_access(8'hFF);
        queue_access(8'h00);
        queue_access(8'hAA);
        queue_access(8'h55);
        queue_access(8'hFF);
        queue_access(8'h01);
        queue_access(8'h80);
        queue_policy(POLICY_LRU);
        queue_access(8'h00);
        queue_access(8'hAA);
        queue_access(8'h7F);
        queue_access(8'h00);

        queue_phase(190);
        queue_policy(POLICY_FIFO);
        queue_phase(180);
        queue_policy(POLICY_LRU);
        queue_phase(180);
        queue_policy(POLICY_FIFO);
        queue_phase(180);
        queue_policy(POLICY_LRU);
        queue_phase(180);
        queue_policy(POLICY_FIFO);
        queue_phase(180);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || start || busy || xlat_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d page accesses over %0d policy writes: %0d results, %0d faults, %0d evictions",
                 n_access, n_policy, n_results, n_faults, n_evicts);
        $display("%0d mismatching or unexpected results", n_errors);
        if (n_errors == 0 && xlat_expected_q.size() == 0) begin
            $display("[page_table_fifo_lru_replacement_unit] OK");
        end else begin
            $display("[page_table_fifo_lru_replacement_unit] ERROR");
        end
        $finish;
    end

endmodule
